// File: rtl/huf_pkg.sv
package huf_pkg;

  localparam int ALPHABET_SIZE = 256;
  localparam int MAX_CODE_LEN  = 32;
  localparam int NODE_COUNT    = 2 * ALPHABET_SIZE - 1;
  localparam int NODE_W        = 9;
  localparam int ENTRY_W       = 8 + 2 * NODE_W;

  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_LOAD   = 2'd1;
  localparam logic [1:0] CMD_DECODE = 2'd2;

  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_PATH = 2'd1;
  localparam logic [1:0] ERR_POOL = 2'd2;

endpackage

// File: rtl/huf_ram.sv
module huf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/huffman_code_tree_decoder_unit.sv
// Huffman decoder whose code tree lives in a 511 x 26 node RAM with one write
// port and one registered read port. Each request carries a command in tuser:
// clear empties the tree and the symbol counter; load walks one code of up to
// 32 bits MSB first, one RAM access per code bit, then writes the symbol;
// decode walks a byte from bit 7 down after setup, one dependent child read per
// bit (the return to the root after a symbol overlaps the leaf check), then
// gives its final response. A decode returns one response per decoded symbol,
// the final one marked with tlast, or a single empty response when the byte
// completes no symbol or the decoder is already done; an undefined path ends
// the decode with an empty error response marked tlast, after any decoded
// symbols. A new request is taken while the last response still waits at the
// output. The user must write total_symbols through cfg_wr_en / cfg_wr_data
// only while the block is idle; the block itself does not enforce it.
module huffman_code_tree_decoder_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [39:0] cfg_wr_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // symbol, code_length, code_bits, data_byte, zero pad
  input  logic [1:0]  s_tuser,   // cmd
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // symbol_out, done_res, error_code, zero pad
  output logic        m_tuser,   // symbol_valid
  output logic        m_tlast
);
  import huf_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_DSTEP, S_DCHECK, S_LSTEP, S_LSYM, S_FIN
  } state_t;

  state_t state;

  logic [7:0]  sym_r;
  logic [31:0] code_r;
  logic [7:0]  byte_r;
  logic [2:0]  bit_idx;
  logic [4:0]  code_idx;
  logic [NODE_W-1:0] cur;
  logic [NODE_W-1:0] node;
  logic [ENTRY_W-1:0] ent;
  logic        use_ent;
  logic [9:0]  next_free;
  logic [39:0] count;
  logic [39:0] total;
  logic        root_empty;
  logic        rd_zero;
  logic [1:0]  res_err;
  logic        pv;
  logic [7:0]  p_sym;
  logic        p_done;
  logic [7:0]  out_sym;
  logic        out_done;
  logic [1:0]  out_err;

  logic               rd_en;
  logic [NODE_W-1:0]  rd_addr;
  logic [ENTRY_W-1:0] rd_data;
  logic               wr_en;
  logic [NODE_W-1:0]  wr_addr;
  logic [ENTRY_W-1:0] wr_data;

  logic [ENTRY_W-1:0] ent_cur;
  logic [ENTRY_W-1:0] ent_in;
  logic [ENTRY_W-1:0] ent_set;
  logic               bit_d;
  logic               bit_l;
  logic [NODE_W-1:0]  child_d;
  logic [NODE_W-1:0]  child_l;
  logic               leaf;
  logic               pool_full;
  logic [39:0]        count_inc;
  logic               done_inc;
  logic               done_now;
  logic               out_ok;
  logic [1:0]         in_cmd;
  logic [5:0]         in_len;
  logic               len_bad;

  huf_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(NODE_COUNT)
  ) u_nodes (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign s_tready = (state == S_IDLE);
  assign m_tdata  = {5'd0, out_err, out_done, out_sym};
  assign in_cmd   = s_tuser;
  assign in_len   = s_tdata[13:8];
  assign len_bad  = (in_len == 6'd0) || (in_len > 6'(MAX_CODE_LEN));

  always_comb begin
    // root reads as empty until first written after a clear
    ent_cur   = (rd_zero && root_empty) ? '0 : rd_data;
    ent_in    = use_ent ? ent : ent_cur;
    bit_d     = byte_r[bit_idx];
    child_d   = bit_d ? ent_cur[25:17] : ent_cur[16:8];
    leaf      = (ent_cur[25:8] == 18'd0);
    bit_l     = code_r[code_idx];
    child_l   = bit_l ? ent_in[25:17] : ent_in[16:8];
    ent_set   = bit_l ? {next_free[NODE_W-1:0], ent_in[16:0]}
                      : {ent_in[25:17], next_free[NODE_W-1:0], ent_in[7:0]};
    pool_full = (next_free >= 10'(NODE_COUNT));
    count_inc = count + 40'd1;
    done_inc  = (count_inc >= total);
    done_now  = (count >= total);
    out_ok    = !m_tvalid || m_tready;

    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = node;
    wr_data = ent_in;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          if (in_cmd == CMD_DECODE && !done_now) begin
            rd_en   = 1'b1;
            rd_addr = cur;
          end else if (in_cmd == CMD_LOAD && !len_bad) begin
            rd_en   = 1'b1;
            rd_addr = '0;
          end
        end
      end
      S_DSTEP: begin
        if (child_d != '0) begin
          rd_en   = 1'b1;
          rd_addr = child_d;
        end
      end
      S_DCHECK: begin
        if (leaf && (!pv || out_ok) && !done_inc && bit_idx != 3'd0) begin
          rd_en   = 1'b1;
          rd_addr = '0;
        end
      end
      S_LSTEP: begin
        if (child_l == '0) begin
          wr_en   = 1'b1;
          wr_data = pool_full ? ent_in : ent_set;
        end else begin
          rd_en   = 1'b1;
          rd_addr = child_l;
        end
      end
      S_LSYM: begin
        wr_en   = 1'b1;
        wr_data = {ent_in[25:8], sym_r};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      m_tvalid   <= 1'b0;
      pv         <= 1'b0;
      root_empty <= 1'b1;
      rd_zero    <= 1'b0;
      next_free  <= 10'd1;
      cur        <= '0;
      count      <= '0;
      total      <= '0;
      use_ent    <= 1'b0;
      res_err    <= ERR_NONE;
    end else begin
      if (cfg_wr_en) begin
        total <= cfg_wr_data;
      end
      if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (rd_en) begin
        rd_zero <= (rd_addr == '0);
      end
      if (wr_en && wr_addr == '0) begin
        root_empty <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            sym_r   <= s_tdata[7:0];
            code_r  <= s_tdata[45:14];
            byte_r  <= s_tdata[53:46];
            res_err <= ERR_NONE;
            pv      <= 1'b0;
            case (in_cmd)
              CMD_CLEAR: begin
                root_empty <= 1'b1;
                next_free  <= 10'd1;
                cur        <= '0;
                count      <= '0;
                state      <= S_FIN;
              end
              CMD_LOAD: begin
                if (len_bad) begin
                  res_err <= ERR_POOL;
                  state   <= S_FIN;
                end else begin
                  node     <= '0;
                  use_ent  <= 1'b0;
                  code_idx <= 5'(in_len - 6'd1);
                  state    <= S_LSTEP;
                end
              end
              CMD_DECODE: begin
                if (done_now) begin
                  state <= S_FIN;
                end else begin
                  bit_idx <= 3'd7;
                  state   <= S_DSTEP;
                end
              end
              default: begin
                state <= S_FIN;
              end
            endcase
          end
        end
        S_DSTEP: begin
          if (child_d == '0) begin
            cur     <= '0;
            res_err <= ERR_PATH;
            state   <= S_FIN;
          end else begin
            cur   <= child_d;
            state <= S_DCHECK;
          end
        end
        S_DCHECK: begin
          if (leaf) begin
            if (!pv || out_ok) begin
              if (pv) begin
                m_tvalid <= 1'b1;
                out_sym  <= p_sym;
                m_tuser  <= 1'b1;
                m_tlast  <= 1'b0;
                out_done <= p_done;
                out_err  <= ERR_NONE;
              end
              pv     <= 1'b1;
              p_sym  <= ent_cur[7:0];
              p_done <= done_inc;
              count  <= count_inc;
              cur    <= '0;
              if (done_inc || bit_idx == 3'd0) begin
                state <= S_FIN;
              end else begin
                bit_idx <= bit_idx - 3'd1;
                state   <= S_DSTEP;
              end
            end
          end else if (bit_idx == 3'd0) begin
            state <= S_FIN;
          end else begin
            bit_idx <= bit_idx - 3'd1;
            state   <= S_DSTEP;
          end
        end
        S_LSTEP: begin
          if (child_l == '0) begin
            if (pool_full) begin
              res_err <= ERR_POOL;
              state   <= S_FIN;
            end else begin
              next_free <= next_free + 10'd1;
              node      <= next_free[NODE_W-1:0];
              ent       <= '0;
              use_ent   <= 1'b1;
              if (code_idx == 5'd0) begin
                state <= S_LSYM;
              end else begin
                code_idx <= code_idx - 5'd1;
              end
            end
          end else begin
            node    <= child_l;
            use_ent <= 1'b0;
            if (code_idx == 5'd0) begin
              state <= S_LSYM;
            end else begin
              code_idx <= code_idx - 5'd1;
            end
          end
        end
        S_LSYM: begin
          state <= S_FIN;
        end
        S_FIN: begin
          if (out_ok) begin
            m_tvalid <= 1'b1;
            if (pv) begin
              // held symbol is final unless an error response follows
              out_sym  <= p_sym;
              m_tuser  <= 1'b1;
              m_tlast  <= (res_err == ERR_NONE);
              out_done <= p_done;
              out_err  <= ERR_NONE;
              pv       <= 1'b0;
              if (res_err == ERR_NONE) begin
                state <= S_IDLE;
              end
            end else begin
              out_sym  <= 8'd0;
              m_tuser  <= 1'b0;
              m_tlast  <= 1'b1;
              out_done <= done_now;
              out_err  <= res_err;
              state    <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
